>>> rtl/core/tfs_pkg.sv
package tfs_pkg;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_YIELD  = 3'd1;
  localparam logic [2:0] OP_SCHED  = 3'd2;
  localparam logic [2:0] OP_EXIT   = 3'd3;
  localparam logic [2:0] OP_GET    = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_QSCAN,
    S_DISPATCH,
    S_RDENT,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       cap;
    logic       do_exit;
    logic       set_st;
    logic [1:0] st_val;
    logic       set_rid_run;
    logic       find_init;
    logic       find_step;
    logic       q_start;
    logic       q_step;
    logic       dispatch;
    logic       load_out;
  } tfs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       tgt_bad;
    logic       tgt_self;
    logic       run_ok;
    logic       q_empty;
    logic       q_full;
    logic       slot_free;
    logic       find_last;
    logic       q_last;
    logic       out_free;
  } tfs_stat_t;

endpackage

>>> rtl/core/tfs_ctrl.sv
module tfs_ctrl
  import tfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tfs_stat_t st,
  output tfs_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (st.op)
          OP_CREATE: begin
            state_nxt = st.full ? S_RDENT : S_FIND;
          end
          OP_YIELD: begin
            if (st.tgt_bad || st.tgt_self) state_nxt = S_RDENT;
            else if (st.q_empty) state_nxt = S_DISPATCH;
            else state_nxt = S_QSCAN;
          end
          OP_SCHED, OP_EXIT: begin
            state_nxt = st.q_empty ? S_RDENT : S_QSCAN;
          end
          default: begin
            state_nxt = S_RDENT;
          end
        endcase
      end
      S_FIND: begin
        if (st.slot_free || st.find_last) state_nxt = S_RDENT;
      end
      S_QSCAN: begin
        if (st.q_last) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_nxt = S_RDENT;
      end
      S_RDENT: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
      end
      S_DECODE: begin
        case (st.op)
          OP_CREATE: begin
            if (st.full) begin
              cmd.set_st = 1'b1;
              cmd.st_val = ST_FULL;
            end else begin
              cmd.find_init = 1'b1;
            end
          end
          OP_YIELD: begin
            if (st.tgt_bad) begin
              cmd.set_st = 1'b1;
              cmd.st_val = ST_BAD;
            end else if (st.tgt_self) begin
              cmd.set_rid_run = 1'b1;
            end else if (!st.q_empty) begin
              cmd.q_start = 1'b1;
            end
          end
          OP_SCHED, OP_EXIT: begin
            cmd.do_exit = (st.op == OP_EXIT);
            if (!st.q_empty) begin
              cmd.q_start = 1'b1;
            end else if (!(st.run_ok && st.op != OP_EXIT)) begin
              // nothing queued and nothing left running
              cmd.set_st = 1'b1;
              cmd.st_val = ST_NONE;
            end
          end
          default: begin
            if (st.run_ok) begin
              cmd.set_rid_run = 1'b1;
            end else begin
              cmd.set_st = 1'b1;
              cmd.st_val = ST_NONE;
            end
          end
        endcase
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (!st.slot_free && st.find_last) begin
          cmd.set_st = 1'b1;
          cmd.st_val = ST_FULL;
        end
      end
      S_QSCAN: begin
        cmd.q_step = 1'b1;
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
      end
      S_RDENT: begin
        cmd = '0;
      end
      S_RESULT: begin
        cmd.load_out = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/tfs_dp.sv
module tfs_dp
  import tfs_pkg::*;
#(
  parameter int unsigned NUM_THREADS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  tfs_cmd_t              cmd,
  output tfs_stat_t             st,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned IW = $clog2(NUM_THREADS);
  localparam int unsigned CW = $clog2(NUM_THREADS + 1);
  localparam logic [NUM_THREADS-1:0] SLOT0 = NUM_THREADS'(1);
  localparam logic [IW-1:0] LAST_ID = IW'(NUM_THREADS - 1);

  // latched request
  logic [2:0]    op_r;
  logic [7:0]    tgt_r;
  logic [31:0]   addr_r;
  logic [31:0]   param_r;
  logic [IW-1:0] before_r;
  logic [IW-1:0] id_r;

  // thread table and scheduler state
  logic [NUM_THREADS-1:0] valid_r;
  logic [NUM_THREADS-1:0] started_r;
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          live_r;
  logic [IW-1:0]          run_r;
  logic [IW-1:0]          last_r;

  // walk counters
  logic [IW-1:0] scan_r;
  logic [IW-1:0] tries_r;
  logic [IW-1:0] qi_r;
  logic          found_r;

  // result fields
  logic [1:0]    st_r;
  logic [IW-1:0] rid_r;
  logic          fresh_r;

  logic                  out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // ready queue and entry table
  logic [IW-1:0] q_mem [NUM_THREADS];
  logic [IW-1:0] q_rd_r;
  logic          q_we;
  logic [IW-1:0] q_waddr;
  logic [IW-1:0] q_wdata;
  logic [IW-1:0] q_raddr;
  logic [63:0]   ent_mem [NUM_THREADS];
  logic [63:0]   ent_rd_r;

  logic          run_ok;
  logic          q_full;
  logic          slot_free;
  logic          q_last;
  logic          q_match;
  logic          head_mode;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] scan_inc;
  logic [IW-1:0] last_inc;

  assign run_ok    = valid_r[run_r];
  assign q_full    = (cnt_r >= CW'(NUM_THREADS));
  assign slot_free = !valid_r[scan_r];
  assign cnt_m1    = cnt_r - CW'(1);
  assign q_last    = (CW'(qi_r) == cnt_m1);
  assign head_mode = (op_r != OP_YIELD);
  assign q_match   = head_mode ? (qi_r == '0) : (q_rd_r == id_r);
  assign scan_inc  = (scan_r == LAST_ID) ? '0 : scan_r + IW'(1);
  assign last_inc  = (last_r == LAST_ID) ? '0 : last_r + IW'(1);

  always_comb begin
    st           = '0;
    st.op        = op_r;
    st.full      = (live_r >= CW'(NUM_THREADS));
    st.tgt_bad   = (tgt_r >= 8'(NUM_THREADS)) || !valid_r[tgt_r[IW-1:0]];
    st.tgt_self  = (tgt_r[IW-1:0] == run_r);
    st.run_ok    = run_ok;
    st.q_empty   = (cnt_r == '0);
    st.q_full    = q_full;
    st.slot_free = slot_free;
    st.find_last = (tries_r == LAST_ID);
    st.q_last    = q_last;
    st.out_free  = !out_v_r || out_tready;
  end

  // one write port: tail push, compaction shift or re-queue of the runner
  always_comb begin
    q_we    = 1'b0;
    q_waddr = '0;
    q_wdata = '0;
    if (cmd.find_step && slot_free && !q_full) begin
      q_we    = 1'b1;
      q_waddr = cnt_r[IW-1:0];
      q_wdata = scan_r;
    end else if (cmd.q_step && found_r) begin
      q_we    = 1'b1;
      q_waddr = qi_r - IW'(1);
      q_wdata = q_rd_r;
    end else if (cmd.dispatch && run_ok && !q_full) begin
      q_we    = 1'b1;
      q_waddr = cnt_r[IW-1:0];
      q_wdata = run_r;
    end
  end

  assign q_raddr = (cmd.q_start || q_last) ? '0 : qi_r + IW'(1);

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rd_r <= q_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.find_step && slot_free) ent_mem[scan_r] <= {param_r, addr_r};
    ent_rd_r <= ent_mem[run_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= SLOT0;
      started_r <= SLOT0;
      cnt_r     <= '0;
      live_r    <= CW'(1);
      run_r     <= '0;
      last_r    <= '0;
      out_v_r   <= 1'b0;
    end else begin
      if (cmd.do_exit && run_ok) begin
        valid_r[run_r] <= 1'b0;
        if (live_r != '0) live_r <= live_r - CW'(1);
      end
      if (cmd.find_step && slot_free) begin
        valid_r[scan_r]   <= 1'b1;
        started_r[scan_r] <= 1'b0;
        last_r            <= scan_r;
        live_r            <= live_r + CW'(1);
        if (!q_full) cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.q_step && q_last && (found_r || q_match)) begin
        cnt_r <= cnt_m1;
      end
      if (cmd.dispatch) begin
        started_r[id_r] <= 1'b1;
        run_r           <= id_r;
        if (run_ok && !q_full) cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.load_out) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r     <= in_tdata[2:0];
      tgt_r    <= in_tdata[10:3];
      addr_r   <= in_tdata[42:11];
      param_r  <= in_tdata[74:43];
      id_r     <= in_tdata[3 +: IW];
      before_r <= run_r;
      st_r     <= ST_OK;
      rid_r    <= '0;
      fresh_r  <= 1'b0;
    end
    if (cmd.set_st) st_r <= cmd.st_val;
    if (cmd.set_rid_run) rid_r <= run_r;
    if (cmd.find_init) begin
      scan_r  <= last_inc;
      tries_r <= '0;
    end
    if (cmd.find_step) begin
      if (slot_free) begin
        rid_r <= scan_r;
      end else begin
        scan_r  <= scan_inc;
        tries_r <= tries_r + IW'(1);
      end
    end
    if (cmd.q_start) begin
      qi_r    <= '0;
      found_r <= 1'b0;
    end
    if (cmd.q_step) begin
      qi_r <= qi_r + IW'(1);
      if (!found_r && q_match) begin
        found_r <= 1'b1;
        // head of the queue becomes the dispatch target
        if (head_mode) id_r <= q_rd_r;
      end
    end
    if (cmd.dispatch) begin
      fresh_r <= !started_r[id_r];
      if (op_r == OP_YIELD) rid_r <= run_r;
    end
    if (cmd.load_out) begin
      out_data_r <= {4'b0,
                     run_ok ? ent_rd_r[63:32] : 32'd0,
                     run_ok ? ent_rd_r[31:0] : 32'd0,
                     fresh_r,
                     (run_r != before_r),
                     4'(run_r),
                     4'(rid_r),
                     st_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/core/thread_table_fifo_scheduler_top.sv
// channel  dir  handshake          payload
// in_      in   in_tvalid/tready   opcode, target_thread, entry_addr, entry_param
// out_     out  out_tvalid/tready  status, result_id, running_thread, switched,
//                                  first_run, run_entry_addr, run_entry_param
//
// one request at a time; get, bad or self yield, full create and schedule or exit
// with nothing queued go from decode straight to the entry read and the result
// create probes slots in turn, starting after the last created slot
// yield, schedule and exit walk a non-empty ready queue entry by entry before dispatch
// rst_n is synchronous; entry table and queue memories are not cleared
// a new request is taken while the previous result waits in the output register

module thread_table_fifo_scheduler_top
  import tfs_pkg::*;
#(
  parameter int unsigned NUM_THREADS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // opcode[2:0], target_thread[10:3], entry_addr[42:11], entry_param[74:43], zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[1:0], result_id[5:2], running_thread[9:6], switched[10], first_run[11],
  // run_entry_addr[43:12], run_entry_param[75:44], zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  tfs_cmd_t  cmd;
  tfs_stat_t st;

  tfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tfs_dp #(
    .NUM_THREADS (NUM_THREADS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in progress");

  // live count keeps a free slot reachable within one full sweep
  a_find_hits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.find_step && st.find_last |-> st.slot_free)
    else $error("free slot search ran out with table not full");

  // the ready queue never overflows on a re-queue
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dispatch && st.run_ok |-> !st.q_full)
    else $error("ready queue full on dispatch");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tfs_pkg::*;

  localparam int unsigned NUM_THREADS = 16;
  localparam int N_RANDOM    = 1910;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 40;

  // codes beyond get, answered as get
  localparam logic [2:0] OP_RSV5 = 3'd5;
  localparam logic [2:0] OP_RSV6 = 3'd6;
  localparam logic [2:0] OP_RSV7 = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  target;
    logic [31:0] addr;
    logic [31:0] param;
  } sched_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  rid;
    logic [3:0]  run;
    logic        sw;
    logic        fr;
    logic [31:0] eaddr;
    logic [31:0] eparam;
  } sched_rsp_t;

  typedef struct {
    sched_req_t req;
    int         reps;
    bit         typed;
    sched_rsp_t rsp;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  thread_table_fifo_scheduler_top #(
    .NUM_THREADS(NUM_THREADS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // scheduler state as the predictor sees it
  bit          slot_live    [NUM_THREADS];
  bit          slot_ran     [NUM_THREADS];
  logic [31:0] slot_addr    [NUM_THREADS];
  logic [31:0] slot_param   [NUM_THREADS];
  logic [3:0]  ready_ids    [$];
  logic [3:0]  cur_run;
  logic [3:0]  last_new;
  int          live_cnt;

  sched_rsp_t pending_results[$];
  stim_row_t  stim_rows[$];
  bit         failed   = 1'b0;
  bit         calm     = 1'b0;
  bit         hold_req = 1'b0;

  // make id the running thread, return 1 if it never ran before
  function automatic logic run_thread(input logic [3:0] id);
    logic fresh;
    fresh        = !slot_ran[id];
    slot_ran[id] = 1'b1;
    cur_run      = id;
    return fresh;
  endfunction

  function automatic sched_rsp_t predict_schedule(input sched_req_t r);
    sched_rsp_t o;
    logic [3:0] prev;
    logic [3:0] s;
    logic [3:0] head;
    bit         found;
    int         i;
    o    = '0;
    prev = cur_run;
    case (r.op)
      OP_CREATE: begin
        found = 1'b0;
        if (live_cnt < NUM_THREADS) begin
          s = last_new;
          for (i = 0; i < NUM_THREADS && !found; i++) begin
            s = s + 4'd1;
            if (!slot_live[s]) found = 1'b1;
          end
          if (found) begin
            last_new      = s;
            slot_live[s]  = 1'b1;
            slot_ran[s]   = 1'b0;
            slot_addr[s]  = r.addr;
            slot_param[s] = r.param;
            if (ready_ids.size() < NUM_THREADS) ready_ids.push_back(s);
            live_cnt++;
            o.rid = s;
          end
        end
        if (!found) o.status = ST_FULL;
      end
      OP_YIELD: begin
        if (r.target >= NUM_THREADS) begin
          o.status = ST_BAD;
        end else if (!slot_live[r.target[3:0]]) begin
          o.status = ST_BAD;
        end else if (r.target[3:0] == cur_run) begin
          o.rid = cur_run;
        end else begin
          found = 1'b0;
          for (i = 0; i < ready_ids.size() && !found; i++) begin
            if (ready_ids[i] == r.target[3:0]) begin
              ready_ids.delete(i);
              found = 1'b1;
            end
          end
          if (slot_live[cur_run] && ready_ids.size() < NUM_THREADS)
            ready_ids.push_back(cur_run);
          o.rid = cur_run;
          o.fr  = run_thread(r.target[3:0]);
        end
      end
      OP_SCHED, OP_EXIT: begin
        if (r.op == OP_EXIT && slot_live[cur_run]) begin
          slot_live[cur_run] = 1'b0;
          if (live_cnt > 0) live_cnt--;
        end
        if (ready_ids.size() > 0) begin
          head = ready_ids.pop_front();
          if (slot_live[cur_run]) ready_ids.push_back(cur_run);
          o.fr = run_thread(head);
        end else if (!slot_live[cur_run]) begin
          o.status = ST_NONE;
        end
      end
      default: begin
        if (slot_live[cur_run]) o.rid = cur_run;
        else o.status = ST_NONE;
      end
    endcase
    o.run = cur_run;
    o.sw  = (cur_run != prev);
    if (slot_live[cur_run]) begin
      o.eaddr  = slot_addr[cur_run];
      o.eparam = slot_param[cur_run];
    end
    return o;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [7:0] tgt,
                                  input logic [31:0] a, input logic [31:0] p,
                                  input int reps);
    stim_row_t row;
    row.req   = {op, tgt, a, p};
    row.reps  = reps;
    row.typed = 1'b0;
    row.rsp   = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_typed(input logic [2:0] op, input logic [7:0] tgt,
                                    input logic [31:0] a, input logic [31:0] p,
                                    input logic [1:0] st, input logic [3:0] rid,
                                    input logic [3:0] run, input logic sw,
                                    input logic fr, input logic [31:0] ea,
                                    input logic [31:0] ep);
    stim_row_t row;
    row.req   = {op, tgt, a, p};
    row.reps  = 1;
    row.typed = 1'b1;
    row.rsp   = {st, rid, run, sw, fr, ea, ep};
    stim_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  // starts on a falling edge and returns at the rising edge of the transfer
  task automatic send_req(input sched_req_t r, input bit typed, input sched_rsp_t want);
    sched_rsp_t p;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {5'd0, r.param, r.addr, r.target, r.op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    p = predict_schedule(r);
    pending_results.push_back(typed ? want : p);
  endtask

  always @(posedge clk) begin
    sched_rsp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, out_tdata);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("status",          32'(want.status), 32'(out_tdata[1:0]));
        check_field("result_id",       32'(want.rid),    32'(out_tdata[5:2]));
        check_field("running_thread",  32'(want.run),    32'(out_tdata[9:6]));
        check_field("switched",        32'(want.sw),     32'(out_tdata[10]));
        check_field("first_run",       32'(want.fr),     32'(out_tdata[11]));
        check_field("run_entry_addr",  want.eaddr,       out_tdata[43:12]);
        check_field("run_entry_param", want.eparam,      out_tdata[75:44]);
      end
    end
  end

  // result side: random stalls, one long hold-off while the sender keeps going
  initial begin
    bit hold_done;
    int k;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
      end
      out_tready <= calm || ($urandom_range(99) >= 25);
    end
  end

  initial begin
    sched_req_t r;
    logic [2:0] misc_ops[4];
    int         create_bias;
    int         pick;
    int         j;
    int         n;
    misc_ops = '{OP_GET, OP_RSV5, OP_RSV6, OP_RSV7};

    for (j = 0; j < NUM_THREADS; j++) begin
      slot_live[j]  = 1'b0;
      slot_ran[j]   = 1'b0;
      slot_addr[j]  = '0;
      slot_param[j] = '0;
    end
    slot_live[0] = 1'b1;
    slot_ran[0]  = 1'b1;
    cur_run      = '0;
    last_new     = '0;
    live_cnt     = 1;

    // the initial thread exits first, so its never written entry is never read out
    add_typed(OP_EXIT,   8'd0,  '0, '0, ST_NONE, 4'd0, 4'd0, 1'b0, 1'b0, '0, '0);
    add_typed(OP_GET,    8'd0,  '0, '0, ST_NONE, 4'd0, 4'd0, 1'b0, 1'b0, '0, '0);
    add_typed(OP_SCHED,  8'd0,  '0, '0, ST_NONE, 4'd0, 4'd0, 1'b0, 1'b0, '0, '0);
    add_typed(OP_YIELD,  8'd0,  '0, '0, ST_BAD,  4'd0, 4'd0, 1'b0, 1'b0, '0, '0);
    add_typed(OP_CREATE, 8'd0, 32'hFFFF_FFFF, 32'h8000_0000,
              ST_OK, 4'd1, 4'd0, 1'b0, 1'b0, '0, '0);
    add_typed(OP_CREATE, 8'hFF, 32'h0, 32'h7FFF_FFFF,
              ST_OK, 4'd2, 4'd0, 1'b0, 1'b0, '0, '0);
    add_typed(OP_SCHED,  8'd0,  '0, '0, ST_OK, 4'd0, 4'd1, 1'b1, 1'b1,
              32'hFFFF_FFFF, 32'h8000_0000);
    add_typed(OP_YIELD,  8'd1,  '0, '0, ST_OK, 4'd1, 4'd1, 1'b0, 1'b0,
              32'hFFFF_FFFF, 32'h8000_0000);
    add_typed(OP_YIELD,  8'hFF, '0, '0, ST_BAD, 4'd0, 4'd1, 1'b0, 1'b0,
              32'hFFFF_FFFF, 32'h8000_0000);
    add_typed(OP_YIELD,  8'd16, '0, '0, ST_BAD, 4'd0, 4'd1, 1'b0, 1'b0,
              32'hFFFF_FFFF, 32'h8000_0000);
    add_row(OP_YIELD,  8'd2, '0, '0, 1);
    add_row(OP_SCHED,  8'd0, '0, '0, 1);
    add_row(OP_RSV5,   8'd0, '0, '0, 1);
    add_row(OP_RSV7,   8'd0, '0, '0, 1);
    // fill the table, the search wraps back to slot zero at the end
    add_row(OP_CREATE, 8'd0, '0, '0, NUM_THREADS - 2);
    add_typed(OP_CREATE, 8'd0, 32'h1234_5678, 32'h1234_5678,
              ST_FULL, 4'd0, 4'd1, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000);
    add_row(OP_EXIT,   8'd0, '0, '0, 3);
    add_row(OP_YIELD,  8'd0, '0, '0, 1);
    add_row(OP_GET,    8'd0, '0, '0, 1);
    add_row(OP_SCHED,  8'd0, '0, '0, 1);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[k]) begin
      for (j = 0; j < stim_rows[k].reps; j++) begin
        r = stim_rows[k].req;
        // repeated rows carry fresh entry data each time
        if (stim_rows[k].reps > 1) begin
          r.addr  = $urandom;
          r.param = $urandom;
        end
        send_req(r, stim_rows[k].typed, stim_rows[k].rsp);
      end
    end

    create_bias = 30;
    for (n = 0; n < N_RANDOM; n++) begin
      // phases lean toward filling or draining the table
      if (n % 128 == 0) create_bias = $urandom_range(60, 10);
      calm = (n >= 700 && n < 1000);
      if (n == 400) hold_req = 1'b1;
      if (n == 1300) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      r.addr   = $urandom;
      r.param  = $urandom;
      r.target = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                          : 8'($urandom_range(NUM_THREADS - 1));
      if ($urandom_range(99) < create_bias) begin
        r.op = OP_CREATE;
      end else begin
        pick = $urandom_range(99);
        if (pick < 35)      r.op = OP_YIELD;
        else if (pick < 60) r.op = OP_SCHED;
        else if (pick < 80) r.op = OP_EXIT;
        else                r.op = misc_ops[$urandom_range(3)];
      end
      send_req(r, 1'b0, '0);
    end

    calm = 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tfs_pkg.sv
rtl/core/tfs_ctrl.sv
rtl/core/tfs_dp.sv
rtl/core/thread_table_fifo_scheduler_top.sv
tb/sv/testbench.sv
